@@ sv/dqpi_pkg.sv @@
`default_nettype none

package dqpi_pkg;

  localparam int unsigned DqDepthDefault     = 16;
  localparam int unsigned DqDataWidthDefault = 32;

  typedef enum logic [2:0] {
    KIND_PUSH_BACK  = 3'd0,
    KIND_PUSH_FRONT = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_INSERT     = 3'd3,
    KIND_PEEK       = 3'd4
  } dq_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_FIN
  } dq_state_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] item_value;
    logic [3:0]  offset;
  } dq_req_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] data_out;
    logic [4:0]  occupancy;
  } dq_rsp_t;

endpackage

`default_nettype wire

@@ sv/deque_with_positional_insert_top.sv @@
// Channel  | Handshake                | Payload
// request  | in_valid_i / in_ready_o  | in_req_i  (dq_req_t: kind, item_value, offset)
// response | out_valid_o / out_ready_i| out_rsp_o (dq_rsp_t: ok, data_out, occupancy)
//
// One request at a time. Push, pop, peek and rejected requests go from accept
// straight to the result. An insert that moves k entries first passes through
// a shift phase: one memory read and one write per moved entry, pipelined
// through the single read port and single write port of the entry store.
// Reset clears the control state, head and count; the store needs no clearing pass.
// A stalled response holds the next result back but not the next request.
`default_nettype none

module deque_with_positional_insert_top
  import dqpi_pkg::*;
#(
  parameter int unsigned DEPTH      = DqDepthDefault,
  parameter int unsigned DATA_WIDTH = DqDataWidthDefault
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire dq_req_t in_req_i,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output dq_rsp_t      out_rsp_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned OW = (CW > 4) ? CW : 4;

  function automatic logic [AW-1:0] slot_f(input logic [AW-1:0] base,
                                           input logic [CW-1:0] pos);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(pos);
    if (s >= (CW+1)'(DEPTH)) s = s - (CW+1)'(DEPTH);
    return s[AW-1:0];
  endfunction

  // entry store
  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic [DATA_WIDTH-1:0] rdata_q;

  dq_state_e       state_q, state_d;
  logic [AW-1:0]   head_q, head_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   i_q, i_d;
  logic [CW-1:0]   pos_q, pos_d;
  logic [DATA_WIDTH-1:0] val_q, val_d;
  logic            wb_valid_q, wb_valid_d;
  logic [AW-1:0]   wb_addr_q, wb_addr_d;
  logic            res_ok_q, res_ok_d;
  logic            res_rd_q, res_rd_d;
  logic            out_valid_q, out_valid_d;
  dq_rsp_t         out_rsp_q, out_rsp_d;

  logic                  accept, full, empty, off_lt, off_zero;
  logic                  start_shift, shift_done, load_out;
  logic [OW-1:0]         off_x, cnt_x;
  logic [AW-1:0]         head_dec, head_inc;
  logic [63:0]           in_wide, rd_wide;
  logic [DATA_WIDTH-1:0] in_word;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  always_comb begin
    full     = (count_q == CW'(DEPTH));
    empty    = (count_q == '0);
    off_x    = OW'(in_req_i.offset);
    cnt_x    = OW'(count_q);
    off_lt   = (off_x < cnt_x);
    off_zero = (in_req_i.offset == '0);
    head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
    head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
    in_wide  = 64'(in_req_i.item_value);
    in_word  = in_wide[DATA_WIDTH-1:0];
    rd_wide  = 64'(rdata_q);
    // insert that lands strictly inside the occupied range
    start_shift = accept && (in_req_i.kind == KIND_INSERT) && !full && off_lt && !off_zero;
    shift_done  = (i_q == pos_q) && !wb_valid_q;
    load_out    = !out_valid_q || out_ready_i;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept) state_d = start_shift ? ST_SHIFT : ST_FIN;
      ST_SHIFT: if (shift_done) state_d = ST_FIN;
      ST_FIN:   if (load_out) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = '0;
    mem_raddr   = '0;
    mem_wdata   = in_word;
    head_d      = head_q;
    count_d     = count_q;
    i_d         = i_q;
    pos_d       = pos_q;
    val_d       = val_q;
    wb_valid_d  = wb_valid_q;
    wb_addr_d   = wb_addr_q;
    res_ok_d    = res_ok_q;
    res_rd_d    = res_rd_q;
    out_valid_d = out_valid_q;
    out_rsp_d   = out_rsp_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_ok_d = 1'b0;
          res_rd_d = 1'b0;
          unique case (in_req_i.kind)
            KIND_PUSH_BACK: begin
              if (!full) begin
                mem_we    = 1'b1;
                mem_waddr = slot_f(head_q, count_q);
                count_d   = count_q + CW'(1);
                res_ok_d  = 1'b1;
              end
            end
            KIND_PUSH_FRONT: begin
              if (!full) begin
                mem_we    = 1'b1;
                mem_waddr = head_dec;
                head_d    = head_dec;
                count_d   = count_q + CW'(1);
                res_ok_d  = 1'b1;
              end
            end
            KIND_POP_FRONT: begin
              if (!empty) begin
                mem_re    = 1'b1;
                mem_raddr = head_q;
                head_d    = head_inc;
                count_d   = count_q - CW'(1);
                res_ok_d  = 1'b1;
                res_rd_d  = 1'b1;
              end
            end
            KIND_INSERT: begin
              if (!full) begin
                count_d  = count_q + CW'(1);
                res_ok_d = 1'b1;
                if (!off_lt) begin
                  mem_we    = 1'b1;
                  mem_waddr = head_dec;
                  head_d    = head_dec;
                end else if (off_zero) begin
                  mem_we    = 1'b1;
                  mem_waddr = slot_f(head_q, count_q);
                end else begin
                  i_d        = count_q;
                  pos_d      = CW'(cnt_x - off_x);
                  val_d      = in_word;
                  wb_valid_d = 1'b0;
                end
              end
            end
            KIND_PEEK: begin
              if (off_lt) begin
                mem_re    = 1'b1;
                mem_raddr = slot_f(head_q, CW'(off_x));
                res_ok_d  = 1'b1;
                res_rd_d  = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SHIFT: begin
        // read entry i-1 now, write it to slot i next cycle
        if (i_q != pos_q) begin
          mem_re     = 1'b1;
          mem_raddr  = slot_f(head_q, i_q - CW'(1));
          wb_valid_d = 1'b1;
          wb_addr_d  = slot_f(head_q, i_q);
          i_d        = i_q - CW'(1);
        end else begin
          wb_valid_d = 1'b0;
        end
        if (wb_valid_q) begin
          mem_we    = 1'b1;
          mem_waddr = wb_addr_q;
          mem_wdata = rdata_q;
        end else if (i_q == pos_q) begin
          mem_we    = 1'b1;
          mem_waddr = slot_f(head_q, pos_q);
          mem_wdata = val_q;
        end
      end
      ST_FIN: ;
      default: ;
    endcase

    if (state_q == ST_FIN && load_out) begin
      out_valid_d         = 1'b1;
      out_rsp_d.ok        = res_ok_q;
      out_rsp_d.data_out  = res_rd_q ? rd_wide[31:0] : 32'd0;
      out_rsp_d.occupancy = 5'(count_q);
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      wb_valid_q  <= 1'b0;
      res_ok_q    <= 1'b0;
      res_rd_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      wb_valid_q  <= wb_valid_d;
      res_ok_q    <= res_ok_d;
      res_rd_q    <= res_rd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q       <= i_d;
    pos_q     <= pos_d;
    val_q     <= val_d;
    wb_addr_q <= wb_addr_d;
    out_rsp_q <= out_rsp_d;
  end

endmodule

`default_nettype wire

@@ sv/dqpi_checker.sv @@
`default_nettype none

module dqpi_checker
  import dqpi_pkg::*;
#(
  parameter int unsigned DEPTH = DqDepthDefault
) (
  input wire logic    clk_i,
  input wire logic    rst_ni,
  input wire logic    in_valid_i,
  input wire logic    in_ready_o,
  input wire dq_req_t in_req_i,
  input wire logic    out_valid_o,
  input wire logic    out_ready_i,
  input wire dq_rsp_t out_rsp_o
);

  // a response waiting for its taker keeps its contents
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("response changed while stalled");

  // one request in flight: accepting closes the request side in the following cycle
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request side reopened straight after accept");

  a_fail_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.ok |-> out_rsp_o.data_out == 32'd0)
    else $error("rejected request returned data");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (DEPTH > 31) || (32'(out_rsp_o.occupancy) <= DEPTH))
    else $error("occupancy beyond depth");

endmodule

bind deque_with_positional_insert_top dqpi_checker #(.DEPTH(DEPTH)) u_dqpi_checker (.*);

`default_nettype wire

@@ bench/deque_with_positional_insert_top_tb.sv @@
`default_nettype none

module deque_with_positional_insert_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dqpi_pkg::*;

  localparam int unsigned Depth       = DqDepthDefault;
  localparam int          RandomItems = 1150;
  localparam int          CycleLimit  = 600000;
  localparam logic [2:0]  KindUnusedFirst = 3'd5;
  localparam logic [2:0]  KindUnusedMid   = 3'd6;
  localparam logic [2:0]  KindUnusedLast  = 3'd7;

  typedef enum logic [1:0] {
    LOAD_FILL,
    LOAD_DRAIN,
    LOAD_CHURN
  } load_mix_e;

  typedef struct packed {
    dq_req_t    req;
    logic [4:0] reps;
    logic       has_rsp;
    dq_rsp_t    rsp;
  } stim_row_t;

  logic    clk_i       = 1'b0;
  logic    rst_ni      = 1'b0;
  logic    in_valid_i  = 1'b0;
  logic    in_ready_o;
  dq_req_t in_req_i    = '0;
  logic    out_valid_o;
  logic    out_ready_i = 1'b0;
  dq_rsp_t out_rsp_o;

  // shadow copy of the deque
  logic [31:0] shadow_slots [Depth];
  int unsigned shadow_head  = 0;
  int unsigned shadow_count = 0;

  dq_rsp_t awaited_rsp_q [$];
  int      err_count     = 0;
  int      rsp_checked   = 0;
  int      rejected_reqs = 0;
  int      full_hits     = 0;
  int      kind_hits [8] = '{default: 0};
  int      cycle_count   = 0;
  bit      calm_link     = 1'b0;

  deque_with_positional_insert_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic void shadow_insert(input int unsigned pos, input logic [31:0] value);
    for (int unsigned i = shadow_count; i > pos; i--) begin
      shadow_slots[(shadow_head + i) % Depth] = shadow_slots[(shadow_head + i - 1) % Depth];
    end
    shadow_slots[(shadow_head + pos) % Depth] = value;
    shadow_count++;
  endfunction

  function automatic void shadow_push_front(input logic [31:0] value);
    shadow_head = (shadow_head + Depth - 1) % Depth;
    shadow_slots[shadow_head] = value;
    shadow_count++;
  endfunction

  // applies one request to the shadow deque and returns the response it yields
  function automatic dq_rsp_t deque_step_rsp(input dq_req_t req);
    dq_rsp_t rsp;
    bit      full;
    rsp  = '0;
    full = (shadow_count >= Depth);
    case (req.kind)
      KIND_PUSH_BACK: begin
        if (!full) begin
          shadow_insert(shadow_count, req.item_value);
          rsp.ok = 1'b1;
        end
      end
      KIND_PUSH_FRONT: begin
        if (!full) begin
          shadow_push_front(req.item_value);
          rsp.ok = 1'b1;
        end
      end
      KIND_POP_FRONT: begin
        if (shadow_count != 0) begin
          rsp.data_out = shadow_slots[shadow_head];
          shadow_head  = (shadow_head + 1) % Depth;
          shadow_count--;
          rsp.ok = 1'b1;
        end
      end
      KIND_INSERT: begin
        if (!full) begin
          if (req.offset >= shadow_count) shadow_push_front(req.item_value);
          else shadow_insert(shadow_count - req.offset, req.item_value);
          rsp.ok = 1'b1;
        end
      end
      KIND_PEEK: begin
        if (req.offset < shadow_count) begin
          rsp.data_out = shadow_slots[(shadow_head + req.offset) % Depth];
          rsp.ok = 1'b1;
        end
      end
      default: ;
    endcase
    rsp.occupancy = shadow_count[4:0];
    return rsp;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm_link || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [2:0] pick_kind(input load_mix_e mix);
    int r;
    int grow;
    int shrink;
    r = $urandom_range(0, 99);
    case (mix)
      LOAD_FILL:  begin grow = 70; shrink = 15; end
      LOAD_DRAIN: begin grow = 20; shrink = 60; end
      default:    begin grow = 40; shrink = 30; end
    endcase
    if (r < 2) return 3'($urandom_range(KindUnusedFirst, KindUnusedLast));
    if (r < 2 + grow) begin
      case ($urandom_range(0, 3))
        0:       return KIND_PUSH_BACK;
        1:       return KIND_PUSH_FRONT;
        default: return KIND_INSERT;
      endcase
    end
    if (r < 2 + grow + shrink) return KIND_POP_FRONT;
    return KIND_PEEK;
  endfunction

  function automatic logic [3:0] pick_offset();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 4'd0;
    if (r == 1) return 4'hF;
    if (r == 2) return (shadow_count > 15) ? 4'hF : 4'(shadow_count);
    if (shadow_count == 0) return 4'($urandom_range(0, 15));
    return 4'($urandom_range(0, shadow_count - 1));
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic stim_row_t mk_row(input logic [2:0] kind, input logic [31:0] value,
                                       input logic [3:0] offset, input logic [4:0] reps,
                                       input logic has_rsp, input logic ok,
                                       input logic [31:0] data, input logic [4:0] occ);
    stim_row_t row;
    row.req.kind       = kind;
    row.req.item_value = value;
    row.req.offset     = offset;
    row.reps           = reps;
    row.has_rsp        = has_rsp;
    row.rsp.ok         = ok;
    row.rsp.data_out   = data;
    row.rsp.occupancy  = occ;
    return row;
  endfunction

  task automatic send_request(input dq_req_t req, input bit has_rsp, input dq_rsp_t typed_rsp);
    int      gap;
    dq_rsp_t rsp;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (!in_ready_o);
    rsp = deque_step_rsp(req);
    kind_hits[req.kind]++;
    if (!rsp.ok) rejected_reqs++;
    if (shadow_count == Depth) full_hits++;
    awaited_rsp_q.push_back(has_rsp ? typed_rsp : rsp);
  endtask

  always @(posedge clk_i) begin : rsp_check
    dq_rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_rsp_q.size() == 0) begin
        $error("response with none outstanding: ok=%0d data_out=%h occupancy=%0d",
               out_rsp_o.ok, out_rsp_o.data_out, out_rsp_o.occupancy);
        err_count++;
      end else begin
        want = awaited_rsp_q.pop_front();
        rsp_checked++;
        if (out_rsp_o.ok !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, out_rsp_o.ok);
          err_count++;
        end
        if (out_rsp_o.data_out !== want.data_out) begin
          $error("data_out: expected %h, got %h", want.data_out, out_rsp_o.data_out);
          err_count++;
        end
        if (out_rsp_o.occupancy !== want.occupancy) begin
          $error("occupancy: expected %0d, got %0d", want.occupancy, out_rsp_o.occupancy);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_count, awaited_rsp_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // response side back-pressure
  initial begin
    forever begin
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      if (!calm_link) begin
        out_ready_i <= 1'b0;
        repeat (1 + pick_gap()) @(posedge clk_i);
      end
    end
  end

  initial begin
    stim_row_t directed_rows [$];
    dq_req_t   req;
    dq_rsp_t   none;
    load_mix_e mix;
    int        sent;
    int        span;

    none = '0;
    directed_rows = '{
      mk_row(KIND_POP_FRONT,  32'h0,         4'd0,  5'd1,  1'b1, 1'b0, 32'h0,         5'd0),
      mk_row(KIND_PEEK,       32'h0,         4'd0,  5'd1,  1'b1, 1'b0, 32'h0,         5'd0),
      mk_row(KindUnusedLast,  32'hFFFF_FFFF, 4'hF,  5'd1,  1'b1, 1'b0, 32'h0,         5'd0),
      // insert into an empty deque lands at the front
      mk_row(KIND_INSERT,     32'hA5A5_A5A5, 4'hF,  5'd1,  1'b1, 1'b1, 32'h0,         5'd1),
      mk_row(KIND_PUSH_BACK,  32'hFFFF_FFFF, 4'd0,  5'd1,  1'b1, 1'b1, 32'h0,         5'd2),
      mk_row(KIND_PUSH_FRONT, 32'h0000_0000, 4'd0,  5'd1,  1'b1, 1'b1, 32'h0,         5'd3),
      mk_row(KIND_PEEK,       32'h0,         4'd0,  5'd1,  1'b1, 1'b1, 32'h0,         5'd3),
      mk_row(KIND_PEEK,       32'h0,         4'd2,  5'd1,  1'b1, 1'b1, 32'hFFFF_FFFF, 5'd3),
      mk_row(KIND_PEEK,       32'h0,         4'd3,  5'd1,  1'b1, 1'b0, 32'h0,         5'd3),
      // zero offset behaves as push back
      mk_row(KIND_INSERT,     32'h0000_0001, 4'd0,  5'd1,  1'b1, 1'b1, 32'h0,         5'd4),
      mk_row(KIND_INSERT,     32'h0000_0002, 4'd2,  5'd1,  1'b0, 1'b0, 32'h0,         5'd0),
      mk_row(KIND_INSERT,     32'h0000_0003, 4'd4,  5'd1,  1'b0, 1'b0, 32'h0,         5'd0),
      // offset equal to the count goes to the front
      mk_row(KIND_INSERT,     32'h0000_0004, 4'd6,  5'd1,  1'b0, 1'b0, 32'h0,         5'd0),
      mk_row(KIND_PEEK,       32'h0,         4'hF,  5'd1,  1'b1, 1'b0, 32'h0,         5'd7),
      mk_row(KIND_PUSH_BACK,  32'h1234_5670, 4'd0,  5'd9,  1'b0, 1'b0, 32'h0,         5'd0),
      mk_row(KIND_PUSH_BACK,  32'hDEAD_BEEF, 4'd0,  5'd1,  1'b1, 1'b0, 32'h0,         5'd16),
      mk_row(KIND_PUSH_FRONT, 32'hDEAD_BEEF, 4'd0,  5'd1,  1'b1, 1'b0, 32'h0,         5'd16),
      mk_row(KIND_INSERT,     32'hDEAD_BEEF, 4'd5,  5'd1,  1'b1, 1'b0, 32'h0,         5'd16),
      mk_row(KIND_PEEK,       32'h0,         4'hF,  5'd1,  1'b0, 1'b0, 32'h0,         5'd0),
      mk_row(KindUnusedFirst, 32'hFFFF_FFFF, 4'hF,  5'd1,  1'b1, 1'b0, 32'h0,         5'd16),
      mk_row(KIND_POP_FRONT,  32'h0,         4'd0,  5'd16, 1'b0, 1'b0, 32'h0,         5'd0),
      mk_row(KIND_POP_FRONT,  32'h0,         4'd0,  5'd1,  1'b1, 1'b0, 32'h0,         5'd0),
      mk_row(KindUnusedMid,   32'h0,         4'd0,  5'd1,  1'b1, 1'b0, 32'h0,         5'd0),
      mk_row(KIND_INSERT,     32'h5A5A_5A5A, 4'd0,  5'd1,  1'b1, 1'b1, 32'h0,         5'd1),
      mk_row(KIND_POP_FRONT,  32'h0,         4'd0,  5'd1,  1'b1, 1'b1, 32'h5A5A_5A5A, 5'd0)
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      for (int r = 0; r < directed_rows[i].reps; r++) begin
        req = directed_rows[i].req;
        req.item_value = req.item_value + 32'(r);
        send_request(req, directed_rows[i].has_rsp, directed_rows[i].rsp);
      end
    end

    // random part: phases biased to fill, drain or churn the deque
    sent = 0;
    while (sent < RandomItems) begin
      mix       = load_mix_e'($urandom_range(0, 2));
      span      = $urandom_range(20, 60);
      calm_link = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < span && sent < RandomItems; n++) begin
        req.kind       = pick_kind(mix);
        req.item_value = pick_value();
        req.offset     = pick_offset();
        send_request(req, 1'b0, none);
        sent++;
      end
    end
    calm_link = 1'b0;
    in_valid_i <= 1'b0;

    while (awaited_rsp_q.size() != 0) @(posedge clk_i);
    repeat (Depth + 4) @(posedge clk_i);

    $display("Covered %0d push back, %0d push front, %0d pop, %0d insert, %0d peek, %0d unused",
             kind_hits[KIND_PUSH_BACK], kind_hits[KIND_PUSH_FRONT], kind_hits[KIND_POP_FRONT],
             kind_hits[KIND_INSERT], kind_hits[KIND_PEEK],
             kind_hits[KindUnusedFirst] + kind_hits[KindUnusedMid] + kind_hits[KindUnusedLast]);
    $display("%0d responses checked, %0d requests refused, deque full after %0d requests",
             rsp_checked, rejected_reqs, full_hits);
    if (err_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire
